// ===== design/smba_pkg.sv =====
package smba_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ID_W       = 8;
  localparam int ADDR_W     = 16;

  localparam logic [ADDR_W-1:0] REGION_BASE = 16'h0B00;
  localparam logic [ADDR_W-1:0] REGION_CEIL = 16'hC000;

  // command codes
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_UNLOAD = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_ID     = 3'd1;
  localparam logic [2:0] ST_NOT_READY  = 3'd2;
  localparam logic [2:0] ST_NO_MEMORY  = 3'd3;
  localparam logic [2:0] ST_NOT_LOADED = 3'd4;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
    logic [ADDR_W-1:0] loop;
  } slot_entry_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] start_address;
    logic [ADDR_W-1:0] sample_bytes;
    logic [ADDR_W-1:0] sample_loop;
    logic [ADDR_W-1:0] free_bytes;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // input beat taken: latch fields, start table read
    logic commit;   // execute item and load result register
  } dp_cmd_t;

endpackage

// ===== design/smba_if.sv =====
interface smba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  slot_id;
  logic [15:0] byte_count;
  logic [15:0] loop_offset;
  logic        transfer_ok;

  modport source (
    output valid, command, slot_id, byte_count, loop_offset, transfer_ok,
    input  ready
  );
  modport sink (
    input  valid, command, slot_id, byte_count, loop_offset, transfer_ok,
    output ready
  );
endinterface

interface smba_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] start_address;
  logic [15:0] sample_bytes;
  logic [15:0] sample_loop;
  logic [15:0] free_bytes;

  modport source (
    output valid, status, start_address, sample_bytes, sample_loop, free_bytes,
    input  ready
  );
  modport sink (
    input  valid, status, start_address, sample_bytes, sample_loop, free_bytes,
    output ready
  );
endinterface

// ===== design/sample_memory_bump_allocator.sv =====
// An input beat is latched into the field registers and the slot-table read
// register, then the execute/write-back state loads the result register; it
// waits while the previous result still waits in the result register. A new
// beat is taken only in the idle state, once the previous item has executed.
// Reset (rst_n, synchronous, active low) clears all slot valid marks, sets the
// free pointer to 0x0B00 and driver_ready to 0; the slot table is not cleared.
module sample_memory_bump_allocator import smba_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  smba_in_if.sink    in_ch,
  smba_out_if.source out_ch,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  dp_cmd_t dp_cmd;
  result_t result;

  smba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (dp_cmd)
  );

  smba_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (dp_cmd),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_command     (in_ch.command),
    .in_slot_id     (in_ch.slot_id),
    .in_byte_count  (in_ch.byte_count),
    .in_loop_offset (in_ch.loop_offset),
    .in_transfer_ok (in_ch.transfer_ok),
    .result         (result)
  );

  assign out_ch.status        = result.status;
  assign out_ch.start_address = result.start_address;
  assign out_ch.sample_bytes  = result.sample_bytes;
  assign out_ch.sample_loop   = result.sample_loop;
  assign out_ch.free_bytes    = result.free_bytes;

endmodule

// ===== design/smba_ctrl.sv =====
module smba_ctrl import smba_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic exec_go;

  assign in_ready    = (state_r == S_IDLE);
  // result register must be empty or draining this cycle
  assign exec_go     = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.commit  = exec_go;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.capture) state_nxt = S_EXEC;
      S_EXEC: if (exec_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_commit_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r && (state_r == S_IDLE))
    else $error("commit did not load result register");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !cmd.commit)
    else $error("pending result overwritten");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> !cmd.capture)
    else $error("second beat taken before execute");
`endif

endmodule

// ===== design/smba_datapath.sv =====
module smba_datapath import smba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic [1:0]        in_command,
  input  logic [ID_W-1:0]   in_slot_id,
  input  logic [ADDR_W-1:0] in_byte_count,
  input  logic [ADDR_W-1:0] in_loop_offset,
  input  logic              in_transfer_ok,
  output result_t           result
);

  slot_entry_t slot_mem [SLOT_COUNT];

  logic                  drv_ready_r;
  logic [SLOT_COUNT-1:0] valid_r;
  logic [ADDR_W-1:0]     fp_r, fp_nxt;
  logic [1:0]            cmd_r;
  logic [SLOT_W-1:0]     idx_r;
  logic                  bad_id_r;
  logic [ADDR_W-1:0]     count_r;
  logic [ADDR_W-1:0]     loop_r;
  logic                  ok_r;
  slot_entry_t           rd_r;
  result_t               result_r, result_nxt;

  logic              slot_vld;
  logic [ADDR_W-1:0] avail;
  logic [ADDR_W-1:0] entry_end;
  logic              no_mem;
  logic              wr_en;
  logic              set_vld;
  logic              clr_vld;

  assign slot_vld  = valid_r[idx_r];
  assign avail     = REGION_CEIL - fp_r;
  assign entry_end = rd_r.start + rd_r.length;
  assign no_mem    = (count_r == '0) || (count_r > avail);

  always_comb begin
    result_nxt               = '0;
    result_nxt.status        = ST_OK;
    fp_nxt                   = fp_r;
    wr_en                    = 1'b0;
    set_vld                  = 1'b0;
    clr_vld                  = 1'b0;
    if (bad_id_r) begin
      result_nxt.status = ST_BAD_ID;
    end else begin
      case (cmd_r)
        CMD_LOAD: begin
          if (!drv_ready_r) begin
            result_nxt.status = ST_NOT_READY;
          end else if (no_mem) begin
            result_nxt.status = ST_NO_MEMORY;
          end else if (!ok_r) begin
            result_nxt.status = ST_NOT_READY;
          end else begin
            wr_en                    = 1'b1;
            set_vld                  = 1'b1;
            fp_nxt                   = fp_r + count_r;
            result_nxt.start_address = fp_r;
            result_nxt.sample_bytes  = count_r;
            result_nxt.sample_loop   = loop_r;
          end
        end
        CMD_UNLOAD: begin
          if (!slot_vld) begin
            result_nxt.status = ST_NOT_LOADED;
          end else begin
            clr_vld                  = 1'b1;
            // space comes back only if this sample is the last one handed out
            if (entry_end == fp_r) fp_nxt = rd_r.start;
            result_nxt.start_address = rd_r.start;
            result_nxt.sample_bytes  = rd_r.length;
            result_nxt.sample_loop   = rd_r.loop;
          end
        end
        default: begin
          if (!slot_vld) begin
            result_nxt.status = ST_NOT_LOADED;
          end else begin
            result_nxt.start_address = rd_r.start;
            result_nxt.sample_bytes  = rd_r.length;
            result_nxt.sample_loop   = rd_r.loop;
          end
        end
      endcase
    end
    result_nxt.free_bytes = REGION_CEIL - fp_nxt;
  end

  // slot table: one read at capture, one write at the commit of a successful load
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd_r <= slot_mem[in_slot_id[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      slot_mem[idx_r] <= '{start: fp_r, length: count_r, loop: loop_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= in_command;
      idx_r    <= in_slot_id[SLOT_W-1:0];
      bad_id_r <= ({1'b0, in_slot_id} >= (ID_W+1)'(SLOT_COUNT));
      count_r  <= in_byte_count;
      loop_r   <= in_loop_offset;
      ok_r     <= in_transfer_ok;
    end
    if (cmd.commit) begin
      result_r <= result_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drv_ready_r <= 1'b0;
      valid_r     <= '0;
      fp_r        <= REGION_BASE;
    end else begin
      if (cfg_wr_en) drv_ready_r <= cfg_wr_data;
      if (cmd.commit) begin
        fp_r <= fp_nxt;
        if (set_vld) valid_r[idx_r] <= 1'b1;
        if (clr_vld) valid_r[idx_r] <= 1'b0;
      end
    end
  end

  assign result = result_r;

`ifndef SYNTHESIS
  a_fp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fp_r >= REGION_BASE) && (fp_r <= REGION_CEIL))
    else $error("free pointer left the region");
  a_load_marks: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && set_vld) |=> valid_r[$past(idx_r)])
    else $error("loaded slot not marked valid");
  a_refused_keeps_fp: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && (result_nxt.status != ST_OK)) |=> $stable(fp_r))
    else $error("refused command moved free pointer");
  a_unload_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && clr_vld) |=> !valid_r[$past(idx_r)])
    else $error("unloaded slot still valid");
`endif

endmodule
